// ----- rtl/ccdp_pkg.sv -----
// Package for the Cache-Control directive parser: scan and number states,
// keyword tables, character codes and the keyword match result type.
// No dependencies; the parser core and the keyword match import it.
package ccdp_pkg;

  typedef enum logic [1:0] {
    SCAN_TOKEN,
    SCAN_MATCH,
    SCAN_SKIP,
    SCAN_VALDIG
  } scan_mode_t;

  typedef enum logic [1:0] {
    NUM_IDLE,
    NUM_LEAD,
    NUM_DIGITS
  } num_phase_t;

  localparam int KW_COUNT       = 10;
  localparam int KW_MAX_LEN     = 23;
  localparam int FLAG_COUNT     = 6;
  localparam int VALUE_COUNT    = 4;
  localparam int OUT_VALUE_BITS = 32;

  // Keyword 0..5 set a flag; keyword 6..9 start a numeric value.
  localparam logic [3:0] KW_FIRST_VALUE = 4'd6;

  // String literals are right-justified: the first character sits in the
  // highest used byte of each entry.
  localparam logic [KW_MAX_LEN*8-1:0] KW_TEXT [KW_COUNT] = '{
    "no-cache", "no-store", "public", "private", "must-revalidate",
    "only-if-cached", "s-maxage=", "max-age=", "stale-while-revalidate=",
    "stale-if-error="
  };

  localparam logic [4:0] KW_LEN [KW_COUNT] = '{
    5'd8, 5'd8, 5'd6, 5'd7, 5'd15, 5'd14, 5'd9, 5'd8, 5'd23, 5'd15
  };

  // Value slot for keywords 6..9: s-maxage, max-age, stale-while-revalidate,
  // stale-if-error. Slots are max_age, shared_max_age, swr, sie.
  localparam logic [1:0] KW_SLOT [VALUE_COUNT] = '{2'd1, 2'd0, 2'd2, 2'd3};

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_CASE    = 8'h20;

  typedef struct packed {
    logic [KW_COUNT-1:0] mask;
    logic                any;
    logic                hit;
    logic [3:0]          index;
  } kw_match_t;

  // Character of keyword k at position p, or NUL past its end.
  function automatic logic [7:0] kw_char(input int k, input logic [4:0] p);
    int lo;
    lo = 0;
    if (p >= KW_LEN[k]) begin
      return CH_NUL;
    end
    lo = (int'(KW_LEN[k]) - 1 - int'(p)) * 8;
    return KW_TEXT[k][lo +: 8];
  endfunction

endpackage

// ----- rtl/ccdp_channels.sv -----
// Valid/ready channel interfaces of the Cache-Control directive parser:
// the header byte stream and the parsed result.
// No dependencies.
interface ccdp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

interface ccdp_out_if;
  logic               valid;
  logic               ready;
  logic               is_nocache;
  logic               is_nostore;
  logic               is_public;
  logic               is_private;
  logic               is_revalidate;
  logic               is_cached_only;
  logic signed [31:0] max_age;
  logic signed [31:0] shared_max_age;
  logic signed [31:0] stale_reval_age;
  logic signed [31:0] stale_error_age;

  modport source (output valid, output is_nocache, output is_nostore, output is_public,
                  output is_private, output is_revalidate, output is_cached_only,
                  output max_age, output shared_max_age, output stale_reval_age,
                  output stale_error_age, input ready);
  modport sink   (input valid, input is_nocache, input is_nostore, input is_public,
                  input is_private, input is_revalidate, input is_cached_only,
                  input max_age, input shared_max_age, input stale_reval_age,
                  input stale_error_age, output ready);
endinterface

// ----- rtl/cache_control_directive_parser_core.sv -----
// Cache-Control directive parser, top level. Depends on ccdp_pkg, ccdp_channels
// and ccdp_keyword_match.
// A zero byte is first held in the input register; when it is processed, its result is loaded
// into the result register, where it becomes valid.
// Throughput: one header byte per cycle; a zero byte stalls only while the previous result waits.
// Reset (synchronous, rst_n low) empties both registers and clears the scan state.
module cache_control_directive_parser_core #(
  parameter int VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  ccdp_in_if.sink     in_chan,
  ccdp_out_if.source  out_chan
);
  import ccdp_pkg::*;

  localparam int PROD_BITS = VALUE_BITS + 4;
  localparam logic [VALUE_BITS-1:0] CAP = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic [VALUE_BITS-1:0] POS_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

  // Input register
  logic       in_valid_r;
  logic [7:0] in_byte_r;

  // Scan and number state
  scan_mode_t                    mode_r, mode_nxt;
  logic [KW_COUNT-1:0]           mask_r, mask_nxt;
  logic [4:0]                    pos_r, pos_nxt;
  num_phase_t                    phase_r, phase_nxt;
  logic                          neg_r, neg_nxt;
  logic [1:0]                    target_r, target_nxt;
  logic [VALUE_BITS-1:0]         mag_r, mag_nxt;
  logic [FLAG_COUNT-1:0]         flags_r, flags_nxt;
  logic signed [VALUE_BITS-1:0]  values_r [VALUE_COUNT];
  logic signed [VALUE_BITS-1:0]  values_nxt [VALUE_COUNT];
  logic signed [VALUE_BITS-1:0]  values_upd [VALUE_COUNT];

  // Result register
  logic                          out_valid_r;
  logic [FLAG_COUNT-1:0]         out_flags_r;
  logic signed [OUT_VALUE_BITS-1:0] out_values_r [VALUE_COUNT];

  logic proc_fire;
  logic byte_zero;
  logic is_digit;
  logic is_sep;
  logic is_num_space;
  logic eff_token;

  logic [KW_COUNT-1:0] mm_mask;
  logic [4:0]          mm_pos;
  kw_match_t           mm_res;

  logic [PROD_BITS-1:0]  prod;
  logic [VALUE_BITS-1:0] mag_step;
  logic [VALUE_BITS-1:0] commit_val;

  assign byte_zero    = (in_byte_r == CH_NUL);
  assign is_digit     = (in_byte_r >= CH_ZERO) && (in_byte_r <= CH_NINE);
  assign is_sep       = (in_byte_r == CH_SPACE) || (in_byte_r == CH_COMMA) ||
                        (in_byte_r == CH_TAB);
  assign is_num_space = (in_byte_r == CH_SPACE) ||
                        ((in_byte_r >= CH_TAB) && (in_byte_r <= CH_CR));

  // A zero byte can only stall while the previous result has not been taken.
  assign proc_fire = in_valid_r && !(byte_zero && out_valid_r && !out_chan.ready);
  assign in_chan.ready = !in_valid_r || proc_fire;

  // A value keyword's digits end at the first non-digit, which then starts a token.
  assign eff_token = (mode_r == SCAN_TOKEN) || ((mode_r == SCAN_VALDIG) && !is_digit);
  assign mm_mask   = eff_token ? {KW_COUNT{1'b1}} : mask_r;
  assign mm_pos    = eff_token ? 5'd0 : pos_r;

  ccdp_keyword_match u_match (
    .text_byte (in_byte_r),
    .mask      (mm_mask),
    .pos       (mm_pos),
    .result    (mm_res)
  );

  // Decimal accumulate with saturation at 2^(VALUE_BITS-1).
  assign prod = (PROD_BITS'(mag_r) << 3) + (PROD_BITS'(mag_r) << 1) +
                PROD_BITS'(in_byte_r - CH_ZERO);
  assign mag_step = (prod > PROD_BITS'(CAP)) ? CAP : prod[VALUE_BITS-1:0];

  always_comb begin
    num_phase_t            ph1;
    logic                  neg1;
    logic [VALUE_BITS-1:0] mag1;
    logic                  feed_commit;
    logic                  digit_path;
    logic                  value_hit;
    logic                  commit_req;
    logic [1:0]            hit_slot;

    ph1         = phase_r;
    neg1        = neg_r;
    mag1        = mag_r;
    feed_commit = 1'b0;
    digit_path  = 1'b0;
    value_hit   = 1'b0;
    hit_slot    = KW_SLOT[2'(mm_res.index - KW_FIRST_VALUE)];

    mode_nxt  = mode_r;
    mask_nxt  = mask_r;
    pos_nxt   = pos_r;
    flags_nxt = flags_r;

    // Number parse runs ahead of the token scan on the same byte.
    if (!byte_zero && (phase_r != NUM_IDLE)) begin
      if (phase_r == NUM_LEAD) begin
        if (is_num_space) begin
          ph1 = NUM_LEAD;
        end else if ((in_byte_r == CH_PLUS) || (in_byte_r == CH_MINUS)) begin
          neg1 = (in_byte_r == CH_MINUS);
          ph1  = NUM_DIGITS;
        end else begin
          ph1        = NUM_DIGITS;
          digit_path = 1'b1;
        end
      end else begin
        digit_path = 1'b1;
      end
      if (digit_path) begin
        if (is_digit) begin
          mag1 = mag_step;
        end else begin
          feed_commit = 1'b1;
          ph1         = NUM_IDLE;
        end
      end
    end

    // Token scan
    if (mode_r == SCAN_SKIP) begin
      if (in_byte_r == CH_COMMA) begin
        mode_nxt = SCAN_TOKEN;
      end
    end else if ((mode_r == SCAN_VALDIG) && is_digit) begin
      mode_nxt = SCAN_VALDIG;
    end else if (eff_token && is_sep) begin
      mode_nxt = SCAN_TOKEN;
    end else begin
      mask_nxt = mm_res.mask;
      pos_nxt  = mm_pos + 5'd1;
      if (!mm_res.any) begin
        mode_nxt = (in_byte_r == CH_COMMA) ? SCAN_TOKEN : SCAN_SKIP;
      end else if (mm_res.hit) begin
        if (mm_res.index < KW_FIRST_VALUE) begin
          flags_nxt[mm_res.index[2:0]] = 1'b1;
          mode_nxt = SCAN_TOKEN;
        end else begin
          value_hit = 1'b1;
          mode_nxt  = SCAN_VALDIG;
        end
      end else begin
        mode_nxt = SCAN_MATCH;
      end
    end

    commit_req = feed_commit || (value_hit && (ph1 != NUM_IDLE));
    if (byte_zero) begin
      commit_req = (phase_r != NUM_IDLE);
    end

    if (neg1) begin
      commit_val = '0 - mag1;
    end else begin
      commit_val = (mag1 > POS_MAX) ? POS_MAX : mag1;
    end

    for (int i = 0; i < VALUE_COUNT; i++) begin
      if (commit_req && (target_r == 2'(i))) begin
        values_upd[i] = commit_val;
      end else begin
        values_upd[i] = values_r[i];
      end
    end

    if (value_hit) begin
      target_nxt = hit_slot;
      phase_nxt  = NUM_LEAD;
      neg_nxt    = 1'b0;
      mag_nxt    = '0;
    end else begin
      target_nxt = target_r;
      phase_nxt  = ph1;
      neg_nxt    = neg1;
      mag_nxt    = mag1;
    end

    for (int i = 0; i < VALUE_COUNT; i++) begin
      values_nxt[i] = values_upd[i];
    end

    // End of header: everything returns to its reset value.
    if (byte_zero) begin
      mode_nxt   = SCAN_TOKEN;
      mask_nxt   = {KW_COUNT{1'b1}};
      pos_nxt    = 5'd0;
      phase_nxt  = NUM_IDLE;
      neg_nxt    = 1'b0;
      target_nxt = 2'd0;
      mag_nxt    = '0;
      flags_nxt  = '0;
      for (int i = 0; i < VALUE_COUNT; i++) begin
        values_nxt[i] = '1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_valid_r <= in_chan.valid;
    end
    if (in_chan.ready && in_chan.valid) begin
      in_byte_r <= in_chan.text_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= SCAN_TOKEN;
      mask_r   <= {KW_COUNT{1'b1}};
      pos_r    <= 5'd0;
      phase_r  <= NUM_IDLE;
      neg_r    <= 1'b0;
      target_r <= 2'd0;
      mag_r    <= '0;
      flags_r  <= '0;
      for (int i = 0; i < VALUE_COUNT; i++) begin
        values_r[i] <= '1;
      end
    end else if (proc_fire) begin
      mode_r   <= mode_nxt;
      mask_r   <= mask_nxt;
      pos_r    <= pos_nxt;
      phase_r  <= phase_nxt;
      neg_r    <= neg_nxt;
      target_r <= target_nxt;
      mag_r    <= mag_nxt;
      flags_r  <= flags_nxt;
      for (int i = 0; i < VALUE_COUNT; i++) begin
        values_r[i] <= values_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc_fire && byte_zero) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
    if (proc_fire && byte_zero) begin
      out_flags_r <= flags_r;
      for (int i = 0; i < VALUE_COUNT; i++) begin
        out_values_r[i] <= OUT_VALUE_BITS'(values_upd[i]);
      end
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.is_nocache      = out_flags_r[0];
  assign out_chan.is_nostore      = out_flags_r[1];
  assign out_chan.is_public       = out_flags_r[2];
  assign out_chan.is_private      = out_flags_r[3];
  assign out_chan.is_revalidate   = out_flags_r[4];
  assign out_chan.is_cached_only  = out_flags_r[5];
  assign out_chan.max_age         = out_values_r[0];
  assign out_chan.shared_max_age  = out_values_r[1];
  assign out_chan.stale_reval_age = out_values_r[2];
  assign out_chan.stale_error_age = out_values_r[3];

  // The digit scan of a value keyword always has a number parse running.
  a_valdig_has_number: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == SCAN_VALDIG |-> phase_r != NUM_IDLE)
    else $error("value digit scan without an active number parse");

  // The magnitude never exceeds the saturation cap.
  a_mag_capped: assert property (@(posedge clk) disable iff (!rst_n)
    mag_r <= CAP)
    else $error("number magnitude above saturation cap");

  // A held input byte is only ever blocked by an untaken result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !proc_fire |-> out_valid_r && byte_zero)
    else $error("input stalled without a pending result");

  // Each finished header leaves the scanner in its reset state.
  a_header_clears: assert property (@(posedge clk) disable iff (!rst_n)
    proc_fire && byte_zero |=> mode_r == SCAN_TOKEN && phase_r == NUM_IDLE &&
      flags_r == '0 && out_valid_r)
    else $error("state not cleared after end of header");

endmodule

// ----- rtl/ccdp_keyword_match.sv -----
// One keyword match step: narrows the candidate set by one header byte and
// reports the lowest keyword that ends on this byte.
// Depends on ccdp_pkg.
module ccdp_keyword_match (
  input  logic [7:0]                   text_byte,
  input  logic [ccdp_pkg::KW_COUNT-1:0] mask,
  input  logic [4:0]                   pos,
  output ccdp_pkg::kw_match_t          result
);
  import ccdp_pkg::*;

  logic [7:0]          lc;
  logic [KW_COUNT-1:0] keep;
  logic [KW_COUNT-1:0] done;
  logic [5:0]          next_len;

  assign next_len = {1'b0, pos} + 6'd1;

  always_comb begin
    // Only A-Z fold; bytes of 128 and above never match.
    if (text_byte >= CH_UPPER_A && text_byte <= CH_UPPER_Z) begin
      lc = text_byte + CH_CASE;
    end else begin
      lc = text_byte;
    end
    for (int k = 0; k < KW_COUNT; k++) begin
      keep[k] = mask[k] && (pos < KW_LEN[k]) && (kw_char(k, pos) == lc);
      done[k] = keep[k] && ({1'b0, KW_LEN[k]} == next_len);
    end
  end

  always_comb begin
    result.mask  = keep;
    result.any   = |keep;
    result.hit   = |done;
    result.index = '0;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (done[k]) begin
        result.index = 4'(k);
      end
    end
  end

endmodule
